FILE: sv/bmhq_pkg.sv
// Shared types, constants and helper functions of the binary min-heap queue.
package bmhq_pkg;

    localparam int DEPTH        = 64;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 16;

    // Slots are numbered from 1 (the root); slot DEPTH is the last one.
    localparam int SLOT_BITS  = $clog2(DEPTH + 1);
    localparam int LEVELS     = SLOT_BITS;
    localparam int IDX_BITS   = LEVELS - 1;
    localparam int LVL_BITS   = $clog2(LEVELS);
    localparam int ENTRY_BITS = KEY_BITS + PAYLOAD_BITS;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                     operation;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } req_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     out_key;
        logic [PAYLOAD_BITS-1:0] out_payload;
        status_t                 status;
        logic [SLOT_BITS-1:0]    count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    // Work token handed from one level cell to the next.
    typedef struct packed {
        logic                 valid;
        op_t                  op;
        logic [IDX_BITS-1:0]  idx;
        logic [SLOT_BITS-1:0] slot;
        logic [SLOT_BITS-1:0] route;
        logic [LVL_BITS-1:0]  left;
        logic                 shifting;
        logic [SLOT_BITS-1:0] limit;
        entry_t               carry;
    } tok_t;

    // Write of a promoted entry into the level above.
    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] idx;
        entry_t              data;
    } wb_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] idx;
    } fetch_t;

    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        entry_t              wdata;
        logic [IDX_BITS-1:0] raddr_a;
        logic [IDX_BITS-1:0] raddr_b;
    } ram_req_t;

    // Number of slots that live on a level of the tree.
    function automatic int level_words(input int lvl);
        int lo;
        lo = 1 << lvl;
        return ((DEPTH + 1 - lo) < lo) ? (DEPTH + 1 - lo) : lo;
    endfunction

    function automatic int level_addr_bits(input int lvl);
        int w;
        w = level_words(lvl);
        return (w > 1) ? $clog2(w) : 1;
    endfunction

    // Position of the leading one of a slot number, which is its tree level.
    function automatic logic [LVL_BITS-1:0] lead_pos(input logic [SLOT_BITS-1:0] s);
        logic [LVL_BITS-1:0] pos;
        pos = '0;
        for (int i = 0; i < SLOT_BITS; i++) begin
            if (s[i]) begin
                pos = LVL_BITS'(i);
            end
        end
        return pos;
    endfunction

    // Offset of a slot within its level: the slot number without its leading one.
    function automatic logic [IDX_BITS-1:0] level_index(input logic [SLOT_BITS-1:0] s,
                                                        input logic [LVL_BITS-1:0] pos);
        logic [SLOT_BITS-1:0] m;
        m = s & ~(SLOT_BITS'(1) << pos);
        return m[IDX_BITS-1:0];
    endfunction

    // Path bits from the root to a slot, most significant first, left aligned.
    function automatic logic [SLOT_BITS-1:0] route_of(input logic [SLOT_BITS-1:0] s,
                                                      input logic [LVL_BITS-1:0] pos);
        logic [SLOT_BITS-1:0] r;
        r = s << (SLOT_BITS - int'(pos));
        return r;
    endfunction

endpackage

FILE: sv/bmhq_ram.sv
// Simple dual-read, single-write memory with registered read data.
module bmhq_ram #(
    parameter int WORDS     = 2,
    parameter int ADDR_BITS = 1,
    parameter int DATA_BITS = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr_a,
    input  logic [ADDR_BITS-1:0] raddr_b,
    output logic [DATA_BITS-1:0] rdata_a,
    output logic [DATA_BITS-1:0] rdata_b
);

    logic [DATA_BITS-1:0] mem [WORDS];
    logic [DATA_BITS-1:0] rdata_a_reg;
    logic [DATA_BITS-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: sv/bmhq_cell.sv
// One level of the heap tree: compare and move logic for the entries on that level.
module bmhq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  bmhq_pkg::tok_t     tok_in,
    output bmhq_pkg::tok_t     tok_out,
    input  bmhq_pkg::wb_t      wb_in,
    output bmhq_pkg::wb_t      wb_out,
    input  bmhq_pkg::fetch_t   fetch,
    output bmhq_pkg::ram_req_t ram_req,
    input  bmhq_pkg::entry_t   rd_a,
    input  bmhq_pkg::entry_t   rd_b,
    output logic               done
);
    import bmhq_pkg::*;

    tok_t pend_reg, pend_next;
    tok_t tok_reg, tok_next;

    logic                own_we;
    logic [IDX_BITS-1:0] own_waddr;
    entry_t              own_wdata;

    logic [SLOT_BITS:0]   in_child_slot;
    logic                 in_leaf;
    logic [IDX_BITS:0]    in_c0_wide;
    logic [IDX_BITS-1:0]  in_c0_idx;

    logic [SLOT_BITS:0]   c0_slot;
    logic [IDX_BITS:0]    c0_wide;
    logic [IDX_BITS-1:0]  c0_idx;
    logic                 right_ok;
    logic                 take_r;
    entry_t               chosen;
    logic [SLOT_BITS:0]   ch_slot;
    logic [IDX_BITS-1:0]  ch_idx;
    logic                 ch_leaf;
    logic                 swap;
    logic [IDX_BITS:0]    push_wide;

    // Children of the hole carried by an arriving pop token.
    assign in_child_slot = {tok_in.slot, 1'b0};
    assign in_leaf       = in_child_slot > {1'b0, tok_in.limit};
    assign in_c0_wide    = {tok_in.idx, 1'b0};
    assign in_c0_idx     = in_c0_wide[IDX_BITS-1:0];

    // Children examined once the read data is back.
    assign c0_slot  = {pend_reg.slot, 1'b0};
    assign c0_wide  = {pend_reg.idx, 1'b0};
    assign c0_idx   = c0_wide[IDX_BITS-1:0];
    assign right_ok = c0_slot != {1'b0, pend_reg.limit};
    assign take_r   = right_ok && (rd_a.key > rd_b.key);
    assign chosen   = take_r ? rd_b : rd_a;
    assign ch_slot  = c0_slot | (SLOT_BITS + 1)'(take_r);
    assign ch_idx   = c0_idx | IDX_BITS'(take_r);
    assign ch_leaf  = {ch_slot, 1'b0} > {2'b00, pend_reg.limit};

    assign swap      = pend_reg.shifting || (rd_a.key > pend_reg.carry.key);
    assign push_wide = {pend_reg.idx, pend_reg.route[SLOT_BITS-1]};

    always_comb
    begin
        pend_next         = '0;
        tok_next          = '0;
        wb_out            = '0;
        own_we            = 1'b0;
        own_waddr         = '0;
        own_wdata         = '0;
        ram_req.raddr_a   = '0;
        ram_req.raddr_b   = '0;
        done              = 1'b0;

        if (fetch.en)
        begin
            ram_req.raddr_a = '0;
            ram_req.raddr_b = fetch.idx;
        end
        else if (tok_in.valid)
        begin
            if (tok_in.op == OP_PUSH)
            begin
                if (tok_in.left == '0)
                begin
                    // The free slot itself: the carried entry lands here.
                    own_we    = 1'b1;
                    own_waddr = tok_in.idx;
                    own_wdata = tok_in.carry;
                    done      = 1'b1;
                end
                else
                begin
                    ram_req.raddr_a = tok_in.idx;
                    pend_next       = tok_in;
                end
            end
            else
            begin
                if (in_leaf)
                begin
                    wb_out.valid = 1'b1;
                    wb_out.idx   = tok_in.idx;
                    wb_out.data  = tok_in.carry;
                    done         = 1'b1;
                end
                else
                begin
                    ram_req.raddr_a = in_c0_idx;
                    ram_req.raddr_b = in_c0_idx | IDX_BITS'(1);
                    pend_next       = tok_in;
                end
            end
        end

        if (pend_reg.valid)
        begin
            if (pend_reg.op == OP_PUSH)
            begin
                // Once one entry has moved down, every later entry on the path moves too.
                if (swap)
                begin
                    own_we    = 1'b1;
                    own_waddr = pend_reg.idx;
                    own_wdata = pend_reg.carry;
                end
                tok_next          = pend_reg;
                tok_next.idx      = push_wide[IDX_BITS-1:0];
                tok_next.route    = pend_reg.route << 1;
                tok_next.left     = pend_reg.left - LVL_BITS'(1);
                tok_next.shifting = swap;
                tok_next.carry    = swap ? rd_a : pend_reg.carry;
            end
            else
            begin
                wb_out.valid = 1'b1;
                wb_out.idx   = pend_reg.idx;
                if (pend_reg.carry.key > chosen.key)
                begin
                    wb_out.data = chosen;
                    if (ch_leaf)
                    begin
                        own_we    = 1'b1;
                        own_waddr = ch_idx;
                        own_wdata = pend_reg.carry;
                        done      = 1'b1;
                    end
                    else
                    begin
                        tok_next      = pend_reg;
                        tok_next.idx  = ch_idx;
                        tok_next.slot = ch_slot[SLOT_BITS-1:0];
                    end
                end
                else
                begin
                    wb_out.data = pend_reg.carry;
                    done        = 1'b1;
                end
            end
        end

        ram_req.we    = wb_in.valid | own_we;
        ram_req.waddr = wb_in.valid ? wb_in.idx : own_waddr;
        ram_req.wdata = wb_in.valid ? wb_in.data : own_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: sv/binary_min_heap_queue.sv
// Top level of the binary min-heap priority queue: sequencer, level cells and level memories.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  operation, key, payload (bmhq_pkg::req_t)
// rsp      out        rsp_valid / rsp_ready  out_key, out_payload, status, count (rsp_t)
//
// One transaction is worked on at a time; req_ready is high only while the sequencer is idle.
// A push token walks from the root through every level above the new slot: each cell reads
// the entry on the path, compares, and hands the token on; the carried entry lands in the new
// slot. A pop first reads the root and the last entry, then sinks the last entry level by
// level, bounded by the tree height. Both are paced by the registered read of each level memory.
// Rejected transactions (push when full, pop when empty) go straight to the result state.
// Reset clears the entry count, so no memory clearing pass is needed.
// A stalled result is held in the output register; the next request may be taken meanwhile.
module binary_min_heap_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bmhq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bmhq_pkg::rsp_t rsp
);
    import bmhq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_FETCH_WAIT,
        S_RUN,
        S_RESULT
    } state_t;

    state_t               state_reg;
    logic [SLOT_BITS-1:0] count_reg;
    status_t              status_reg;
    entry_t               res_reg;
    logic [LVL_BITS-1:0]  fetch_lvl_reg;
    logic [IDX_BITS-1:0]  fetch_idx_reg;
    tok_t                 push_tok_reg;
    tok_t                 pop_tok_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    tok_t     cell_in  [LEVELS];
    tok_t     cell_out [LEVELS];
    wb_t      wb_up    [LEVELS];
    wb_t      wb_down  [LEVELS];
    fetch_t   fetch_arr[LEVELS];
    ram_req_t ram_req  [LEVELS];
    entry_t   rd_a_arr [LEVELS];
    entry_t   rd_b_arr [LEVELS];
    logic [LEVELS-1:0] done_vec;

    logic [SLOT_BITS-1:0] push_slot;
    logic [LVL_BITS-1:0]  push_pos;
    logic [LVL_BITS-1:0]  last_pos;
    logic                 req_take;
    logic                 rsp_free;

    assign req_ready = (state_reg == S_IDLE);
    assign req_take  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // The new entry of a push goes to the first free slot; a pop takes the last slot.
    assign push_slot = count_reg + SLOT_BITS'(1);
    assign push_pos  = lead_pos(push_slot);
    assign last_pos  = lead_pos(count_reg);

    // Chain of level cells. A push enters at the root level; a pop sift enters at level one,
    // since the cell holding the children of the hole decides what moves up.
    genvar lvl;
    generate
        for (lvl = 0; lvl < LEVELS; lvl++)
        begin : g_level
            localparam int WORDS = level_words(lvl);
            localparam int ABITS = level_addr_bits(lvl);

            if (lvl == 0)
            begin : g_root_in
                assign cell_in[lvl] = push_tok_reg;
            end
            else if (lvl == 1)
            begin : g_first_in
                assign cell_in[lvl] = pop_tok_reg.valid ? pop_tok_reg : cell_out[0];
            end
            else
            begin : g_chain_in
                assign cell_in[lvl] = cell_out[lvl-1];
            end

            if (lvl == LEVELS - 1)
            begin : g_last_wb
                assign wb_down[lvl] = '0;
            end
            else
            begin : g_mid_wb
                assign wb_down[lvl] = wb_up[lvl+1];
            end

            assign fetch_arr[lvl].en  = (state_reg == S_FETCH) &&
                                        ((lvl == 0) || (fetch_lvl_reg == LVL_BITS'(lvl)));
            assign fetch_arr[lvl].idx = fetch_idx_reg;

            bmhq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (cell_in[lvl]),
                .tok_out (cell_out[lvl]),
                .wb_in   (wb_down[lvl]),
                .wb_out  (wb_up[lvl]),
                .fetch   (fetch_arr[lvl]),
                .ram_req (ram_req[lvl]),
                .rd_a    (rd_a_arr[lvl]),
                .rd_b    (rd_b_arr[lvl]),
                .done    (done_vec[lvl])
            );

            bmhq_ram #(
                .WORDS     (WORDS),
                .ADDR_BITS (ABITS),
                .DATA_BITS (ENTRY_BITS)
            ) u_ram (
                .clk     (clk),
                .we      (ram_req[lvl].we),
                .waddr   (ram_req[lvl].waddr[ABITS-1:0]),
                .wdata   (ram_req[lvl].wdata),
                .raddr_a (ram_req[lvl].raddr_a[ABITS-1:0]),
                .raddr_b (ram_req[lvl].raddr_b[ABITS-1:0]),
                .rdata_a (rd_a_arr[lvl]),
                .rdata_b (rd_b_arr[lvl])
            );
        end
    endgenerate

    // Sequencer: takes a transaction, launches the token, and loads the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= ST_OK;
            res_reg       <= '0;
            fetch_lvl_reg <= '0;
            fetch_idx_reg <= '0;
            push_tok_reg  <= '0;
            pop_tok_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            push_tok_reg.valid <= 1'b0;
            pop_tok_reg.valid  <= 1'b0;

            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        res_reg    <= '0;
                        status_reg <= ST_OK;
                        if (req.operation == OP_PUSH)
                        begin
                            if (count_reg == SLOT_BITS'(DEPTH))
                            begin
                                status_reg <= ST_FULL;
                                state_reg  <= S_RESULT;
                            end
                            else
                            begin
                                push_tok_reg.valid     <= 1'b1;
                                push_tok_reg.op        <= OP_PUSH;
                                push_tok_reg.idx       <= '0;
                                push_tok_reg.slot      <= push_slot;
                                push_tok_reg.route     <= route_of(push_slot, push_pos);
                                push_tok_reg.left      <= push_pos;
                                push_tok_reg.shifting  <= 1'b0;
                                push_tok_reg.limit     <= '0;
                                push_tok_reg.carry     <= {req.key, req.payload};
                                count_reg              <= push_slot;
                                state_reg              <= S_RUN;
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                            begin
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_RESULT;
                            end
                            else
                            begin
                                fetch_lvl_reg <= last_pos;
                                fetch_idx_reg <= level_index(count_reg, last_pos);
                                count_reg     <= count_reg - SLOT_BITS'(1);
                                state_reg     <= S_FETCH;
                            end
                        end
                    end
                end

                S_FETCH:
                begin
                    // Root and last entry are read this cycle.
                    state_reg <= S_FETCH_WAIT;
                end

                S_FETCH_WAIT:
                begin
                    res_reg <= rd_a_arr[0];
                    if (count_reg == '0)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        pop_tok_reg.valid    <= 1'b1;
                        pop_tok_reg.op       <= OP_POP;
                        pop_tok_reg.idx      <= '0;
                        pop_tok_reg.slot     <= SLOT_BITS'(1);
                        pop_tok_reg.route    <= '0;
                        pop_tok_reg.left     <= '0;
                        pop_tok_reg.shifting <= 1'b0;
                        pop_tok_reg.limit    <= count_reg;
                        pop_tok_reg.carry    <= rd_b_arr[fetch_lvl_reg];
                        state_reg            <= S_RUN;
                    end
                end

                S_RUN:
                begin
                    if (|done_vec)
                    begin
                        state_reg <= S_RESULT;
                    end
                end

                S_RESULT:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg.out_key     <= res_reg.key;
                        rsp_reg.out_payload <= res_reg.payload;
                        rsp_reg.status      <= status_reg;
                        rsp_reg.count       <= count_reg;
                        rsp_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/bmhq_checker.sv
// Port-level checks on the binary min-heap queue and the bind that attaches them.
module bmhq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input bmhq_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input bmhq_pkg::rsp_t rsp
);
    import bmhq_pkg::*;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.count <= SLOT_BITS'(DEPTH)))
        else $error("result count exceeds heap capacity");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_EMPTY)) |->
        ((rsp.count == '0) && (rsp.out_key == '0) && (rsp.out_payload == '0)))
        else $error("empty-pop result is not clean");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_FULL)) |-> (rsp.count == SLOT_BITS'(DEPTH)))
        else $error("full-push result with count below capacity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while a transaction is in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (.*);

FILE: sim/bmhq_checker.sv
// Checker for the min-heap queue: predicts every result and compares it with the block.
`timescale 1ns / 100ps

module bmhq_tb_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  bmhq_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  bmhq_pkg::rsp_t rsp,
    output int             mismatches,
    output int             outstanding
);
    import bmhq_pkg::*;

    // Own copy of the heap; slot 1 is the root and slot 0 is never used.
    logic [KEY_BITS-1:0]     heap_key [0:DEPTH];
    logic [PAYLOAD_BITS-1:0] heap_pay [0:DEPTH];
    int                      held       = 0;
    int                      fail_count = 0;
    rsp_t                    heap_results_q [$];

    function automatic void note_mismatch(input string what, input longint want,
                                          input longint got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // Applies one transaction to the heap copy and returns the result it must give.
    function automatic rsp_t heap_apply(input req_t r);
        rsp_t                    res;
        int                      slot;
        int                      child;
        logic [KEY_BITS-1:0]     moved_key;
        logic [PAYLOAD_BITS-1:0] moved_pay;
        res = '0;
        res.status = ST_OK;
        if (r.operation == OP_PUSH)
        begin
            if (held >= DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                held++;
                slot = held;
                while (slot > 1 && heap_key[slot / 2] > r.key)
                begin
                    heap_key[slot] = heap_key[slot / 2];
                    heap_pay[slot] = heap_pay[slot / 2];
                    slot = slot / 2;
                end
                heap_key[slot] = r.key;
                heap_pay[slot] = r.payload;
            end
        end
        else if (held == 0)
        begin
            res.status = ST_EMPTY;
        end
        else
        begin
            res.out_key     = heap_key[1];
            res.out_payload = heap_pay[1];
            moved_key = heap_key[held];
            moved_pay = heap_pay[held];
            held--;
            slot = 1;
            while (2 * slot <= held)
            begin
                child = 2 * slot;
                // The right child wins only when the left key is strictly greater.
                if (child != held && heap_key[child] > heap_key[child + 1])
                begin
                    child++;
                end
                if (moved_key <= heap_key[child])
                begin
                    break;
                end
                heap_key[slot] = heap_key[child];
                heap_pay[slot] = heap_pay[child];
                slot = child;
            end
            heap_key[slot] = moved_key;
            heap_pay[slot] = moved_pay;
        end
        res.count = SLOT_BITS'(held);
        return res;
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            held = 0;
            heap_results_q.delete();
        end
        else
        begin
            // Results are checked before new transactions are predicted, as a result
            // can never belong to the transaction accepted at the same edge.
            if (rsp_valid && rsp_ready)
            begin
                if (heap_results_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: result with no transaction waiting: key %0h payload %0h",
                                 $time, rsp.out_key, rsp.out_payload);
                    end
                end
                else
                begin
                    want = heap_results_q.pop_front();
                    if (rsp.out_key !== want.out_key)
                    begin
                        note_mismatch("out_key", want.out_key, rsp.out_key);
                    end
                    if (rsp.out_payload !== want.out_payload)
                    begin
                        note_mismatch("out_payload", want.out_payload, rsp.out_payload);
                    end
                    if (rsp.status !== want.status)
                    begin
                        note_mismatch("status", want.status, rsp.status);
                    end
                    if (rsp.count !== want.count)
                    begin
                        note_mismatch("count", want.count, rsp.count);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                heap_results_q.push_back(heap_apply(req));
            end
        end
        outstanding <= heap_results_q.size();
        mismatches  <= fail_count;
    end

endmodule

FILE: sim/binary_min_heap_queue_tb.sv
// Testbench top for the min-heap queue: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module binary_min_heap_queue_tb;

    import bmhq_pkg::*;

    // The slowest legal run is far below this.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles the result side is held off to fill the block and stall its request side.
    localparam int LONG_HOLD    = 300;
    // Cycles allowed after the last result for anything stray to appear.
    localparam int SETTLE       = 40;
    localparam int FILL_PUSHES  = DEPTH + 4;
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_POPS   = DEPTH + 6;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    int   sent        = 0;

    // Shared between the request and result processes.
    bit   idle_on   = 1'b0;
    bit   long_hold = 1'b0;

    always #5 clk = ~clk;

    binary_min_heap_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    bmhq_tb_checker heap_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("binary_min_heap_queue test failed");
            $finish;
        end
    end

    // Offers one transaction and returns at the edge where it is accepted. Valid is only
    // dropped when an idle burst is taken; otherwise the next transaction follows at once.
    task automatic offer(input op_t op, input logic [KEY_BITS-1:0] k,
                         input logic [PAYLOAD_BITS-1:0] p);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_valid     <= 1'b1;
        req.operation <= op;
        req.key       <= k;
        req.payload   <= p;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent++;
    endtask

    // Waits until every predicted result has been returned. The first edge lets the
    // checker count the transaction accepted at the current edge.
    task automatic wait_quiet();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Keys lean towards a narrow range, so that equal keys meet often and the tie rules
    // on both sift directions are exercised, and towards the extremes of the field.
    function automatic logic [KEY_BITS-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
        begin
            return KEY_BITS'($urandom_range(0, 15));
        end
        else if (sel < 35)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return {1'b1, {(KEY_BITS-1){1'b0}}};
                default: return {1'b0, {(KEY_BITS-1){1'b1}}};
            endcase
        end
        return KEY_BITS'($urandom);
    endfunction

    // Result side: ready comes in random stretches, with idle bursts while idling is on,
    // and one long hold-off on request from the stimulus.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Request side and verdict.
    initial
    begin
        int span;
        int push_pct;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a pop on the empty heap, pushes that cover the key and payload
        // extremes and three equal keys, then pops until the heap is empty once more.
        offer(OP_POP, '0, '0);
        offer(OP_PUSH, '0, '1);
        offer(OP_PUSH, '1, '0);
        offer(OP_PUSH, 32'd5, 16'h0001);
        offer(OP_PUSH, 32'd5, 16'h0002);
        offer(OP_PUSH, 32'd5, 16'h0003);
        offer(OP_PUSH, 32'h8000_0000, 16'h8000);
        offer(OP_PUSH, 32'd1, 16'h5555);
        offer(OP_PUSH, 32'h7fff_ffff, 16'haaaa);
        repeat (9) offer(OP_POP, '1, '1);

        // Fill past capacity so that pushes on a full heap are rejected. The result
        // side is held off meanwhile, so the block backs up and stalls its input.
        idle_on   = 1'b1;
        long_hold = 1'b1;
        repeat (FILL_PUSHES) offer(OP_PUSH, pick_key(), PAYLOAD_BITS'($urandom));

        // Let the block run dry before the mixed traffic starts.
        wait_quiet();

        // Mixed traffic in phases that lean towards pushes, towards pops, or neither,
        // so the heap swings between full and empty. Some phases run without idling.
        while (sent < 18 + FILL_PUSHES + RANDOM_ITEMS)
        begin
            span = $urandom_range(30, 90);
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (span)
            begin
                if ($urandom_range(0, 99) < push_pct)
                begin
                    offer(OP_PUSH, pick_key(), PAYLOAD_BITS'($urandom));
                end
                else
                begin
                    offer(OP_POP, KEY_BITS'($urandom), PAYLOAD_BITS'($urandom));
                end
            end
        end

        // Final part, without idling: pop everything out and run into the empty heap.
        idle_on = 1'b0;
        repeat (DRAIN_POPS) offer(OP_POP, '0, '0);

        wait_quiet();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("binary_min_heap_queue test passed");
        end
        else
        begin
            $display("binary_min_heap_queue test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/bmhq_pkg.sv
sv/bmhq_ram.sv
sv/bmhq_cell.sv
sv/binary_min_heap_queue.sv
sv/bmhq_checker.sv
sim/bmhq_checker.sv
sim/binary_min_heap_queue_tb.sv
